// ===== rtl/dpsq_pkg.sv =====
// Package: constants, entry type and sequencer states of the dual priority sorted queue.
package dpsq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CODE_W      = 16;
	localparam int COUNT_W     = 16;
	localparam int LEVEL_W     = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DRAIN  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] qty;
		logic [LEVEL_W-1:0] lvl;
	} entry_t;

	// per-cell control from the row
	typedef struct packed {
		logic wr;       // insert request to this row
		logic occupied; // cell index below fill count
		logic strict;   // compare with > (all cells but the head)
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

// ===== rtl/dpsq_cell.sv =====
// One cell of a sorted row: holds an entry, keeps, takes the new entry or shifts from its neighbour.
module dpsq_cell
	import dpsq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    prev_entry,
	input  logic      prev_ge,
	output entry_t    entry,
	output logic      ge
);

	entry_t entry_q;

	// entry stays ahead of the new one
	assign ge = ctl.occupied &&
		(ctl.strict ? (entry_q.lvl > new_entry.lvl) : (entry_q.lvl >= new_entry.lvl));

	always_ff @(posedge clk) begin
		if (ctl.wr && !ge) begin
			entry_q <= prev_ge ? new_entry : prev_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ===== rtl/dpsq_row.sv =====
// One bounded queue: a row of cells kept in descending priority, with fill count and overflow flag.
module dpsq_row
	import dpsq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ins,
	input  entry_t           new_entry,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_entry,
	output logic [CNT_W-1:0] fill,
	output logic             ovf
);

	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             full;
	logic             wr;
	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_ge    [QUEUE_DEPTH];

	assign full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign wr   = ins && !full;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    prev_entry;
		logic      prev_ge;

		assign ctl.wr       = wr;
		assign ctl.occupied = (CNT_W'(i) < fill_q);
		assign ctl.strict   = (i != 0);

		if (i == 0) begin : g_head
			assign prev_entry = new_entry;
			assign prev_ge    = 1'b1;
		end else begin : g_body
			assign prev_entry = cell_entry[i-1];
			assign prev_ge    = cell_ge[i-1];
		end

		dpsq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_entry),
			.prev_ge    (prev_ge),
			.entry      (cell_entry[i]),
			.ge         (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (ins) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	assign rd_entry = cell_entry[rd_idx];
	assign fill     = fill_q;
	assign ovf      = ovf_q;

endmodule

// ===== rtl/dual_priority_sorted_queue_core.sv =====
// Top level: two sorted priority queues with insert and in-order drain.
//
// A request is taken at a rising edge with start high and busy low.
// opcode selects insert or drain; queue_select picks one of two queues.
// Insert: is stored at the edge that takes it, gives no result, busy stays low,
// so inserts can be issued back to back. A full queue drops the entry
// and sets its sticky overflow flag. Each queue is a row of cells that
// compare their level with the new one and shift all at once.
// Drain: busy rises and stays high until the final entry is read;
// results follow one per cycle from the read port, each on the result
// ports for one cycle with strobe high; last marks the final one. An
// empty queue gives one result with entry_valid low and last high.
// Drain cost is set by the single read port stepping through the row.
// The receiver cannot stall: results are not held back.
// Reset clears fill counts, overflow flags and the sequencer; stored
// entries are not cleared.
module dual_priority_sorted_queue_core
	import dpsq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic               queue_select,
	input  logic [CODE_W-1:0]  customer_code,
	input  logic [COUNT_W-1:0] item_count,
	input  logic [LEVEL_W-1:0] level,
	output logic               strobe,
	output logic               entry_valid,
	output logic [CODE_W-1:0]  customer_code_out,
	output logic [COUNT_W-1:0] item_count_out,
	output logic [LEVEL_W-1:0] level_out,
	output logic               overflowed,
	output logic               last
);

	state_t           state_q, state_d;
	logic             accept;
	logic             drain_go;
	logic             sel_q;
	logic [IDX_W-1:0] rd_q;
	entry_t           new_entry;
	entry_t           rd_entry [2];
	logic [CNT_W-1:0] fill     [2];
	logic             ovf      [2];
	logic             ins      [2];
	entry_t           cur_entry;
	logic [CNT_W-1:0] cur_fill;
	logic             cur_empty;
	logic             cur_last;
	logic             step;

	assign accept    = start && !busy;
	assign new_entry = '{code: customer_code, qty: item_count, lvl: level};

	for (genvar q = 0; q < 2; q++) begin : g_row
		assign ins[q] = accept && (opcode_t'(opcode) == OP_INSERT) && (queue_select == 1'(q));

		dpsq_row u_row (
			.clk       (clk),
			.arst_n    (arst_n),
			.ins       (ins[q]),
			.new_entry (new_entry),
			.rd_idx    (rd_q),
			.rd_entry  (rd_entry[q]),
			.fill      (fill[q]),
			.ovf       (ovf[q])
		);
	end

	assign cur_entry = rd_entry[sel_q];
	assign cur_fill  = fill[sel_q];
	assign cur_empty = (cur_fill == '0);
	assign cur_last  = cur_empty || ((CNT_W'(rd_q) + CNT_W'(1)) == cur_fill);

	assign drain_go = accept && (opcode_t'(opcode) == OP_DRAIN);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (drain_go) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cur_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				step = 1'b0;
			end
			ST_DRAIN: begin
				busy = 1'b1;
				step = 1'b1;
			end
			default: begin
				busy = 1'b0;
				step = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			rd_q    <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= step;
			if (drain_go) begin
				sel_q <= queue_select;
				rd_q  <= '0;
			end else if (step) begin
				rd_q <= rd_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			entry_valid       <= !cur_empty;
			customer_code_out <= cur_empty ? '0 : cur_entry.code;
			item_count_out    <= cur_empty ? '0 : cur_entry.qty;
			level_out         <= cur_empty ? '0 : cur_entry.lvl;
			overflowed        <= ovf[sel_q];
			last              <= cur_last;
		end
	end

endmodule

// ===== verif/dpsq_checker.sv =====
// Checker for the dual priority sorted queue: shadow queues, expected readouts and comparison.
`timescale 1ns / 1ps

module dpsq_checker
	import dpsq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               opcode,
	input  logic               queue_select,
	input  logic [CODE_W-1:0]  customer_code,
	input  logic [COUNT_W-1:0] item_count,
	input  logic [LEVEL_W-1:0] level,
	input  logic               strobe,
	input  logic               entry_valid,
	input  logic [CODE_W-1:0]  customer_code_out,
	input  logic [COUNT_W-1:0] item_count_out,
	input  logic [LEVEL_W-1:0] level_out,
	input  logic               overflowed,
	input  logic               last,
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked,
	output int                 drops
);

	typedef struct packed {
		logic               valid;
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] qty;
		logic [LEVEL_W-1:0] lvl;
		logic               ovf;
		logic               fin;
	} readout_t;

	entry_t   shadow [2][QUEUE_DEPTH];
	int       fill [2];
	bit       ovf_flag [2];
	readout_t due_readouts [$];
	readout_t want;
	int       errs;
	int       seen;
	int       dropped;

	// descending order; an equal level never overtakes the head
	function automatic void place_entry(int q, entry_t e);
		int n;
		int pos;
		int i;
		n = fill[q];
		if (n >= QUEUE_DEPTH) begin
			ovf_flag[q] = 1'b1;
			dropped++;
			return;
		end
		if (n == 0 || shadow[q][0].lvl < e.lvl) begin
			pos = 0;
		end else begin
			pos = 1;
			while (pos < n && shadow[q][pos].lvl > e.lvl)
				pos++;
		end
		for (i = n; i > pos; i--)
			shadow[q][i] = shadow[q][i-1];
		shadow[q][pos] = e;
		fill[q] = n + 1;
	endfunction

	function automatic void queue_readout(int q);
		readout_t r;
		int i;
		if (fill[q] == 0) begin
			r = '0;
			r.ovf = ovf_flag[q];
			r.fin = 1'b1;
			due_readouts.push_back(r);
			return;
		end
		for (i = 0; i < fill[q]; i++) begin
			r.valid = 1'b1;
			r.code  = shadow[q][i].code;
			r.qty   = shadow[q][i].qty;
			r.lvl   = shadow[q][i].lvl;
			r.ovf   = ovf_flag[q];
			r.fin   = (i + 1 == fill[q]);
			due_readouts.push_back(r);
		end
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = '{0, 0};
			ovf_flag = '{1'b0, 1'b0};
			due_readouts.delete();
			errs = 0;
			seen = 0;
			dropped = 0;
			fail_count <= 0;
			outstanding <= 0;
			results_checked <= 0;
			drops <= 0;
		end else begin
			if (strobe === 1'b1) begin
				seen++;
				if (due_readouts.size() == 0) begin
					$error("result with no drain outstanding");
					errs++;
				end else begin
					want = due_readouts.pop_front();
					compare_field("entry_valid", 32'(want.valid), 32'(entry_valid));
					compare_field("customer_code_out", 32'(want.code),
						32'(customer_code_out));
					compare_field("item_count_out", 32'(want.qty), 32'(item_count_out));
					compare_field("level_out", 32'(want.lvl), 32'(level_out));
					compare_field("overflowed", 32'(want.ovf), 32'(overflowed));
					compare_field("last", 32'(want.fin), 32'(last));
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (opcode == OP_INSERT)
					place_entry(queue_select, {customer_code, item_count, level});
				else
					queue_readout(queue_select);
			end
			fail_count <= errs;
			outstanding <= due_readouts.size();
			results_checked <= seen;
			drops <= dropped;
		end
	end

endmodule

// ===== verif/tb_dual_priority_sorted_queue_core.sv =====
// Testbench top for the dual priority sorted queue: request stimulus, reset, clock and verdict.
`timescale 1ns / 1ps

module tb_dual_priority_sorted_queue_core;
	import dpsq_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic               queue_select;
	logic [CODE_W-1:0]  customer_code;
	logic [COUNT_W-1:0] item_count;
	logic [LEVEL_W-1:0] level;
	logic               strobe;
	logic               entry_valid;
	logic [CODE_W-1:0]  customer_code_out;
	logic [COUNT_W-1:0] item_count_out;
	logic [LEVEL_W-1:0] level_out;
	logic               overflowed;
	logic               last;

	int fails;
	int outstanding;
	int results_checked;
	int drops;
	int n_insert;
	int n_drain;
	int idle_pct;

	dual_priority_sorted_queue_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.opcode            (opcode),
		.queue_select      (queue_select),
		.customer_code     (customer_code),
		.item_count        (item_count),
		.level             (level),
		.strobe            (strobe),
		.entry_valid       (entry_valid),
		.customer_code_out (customer_code_out),
		.item_count_out    (item_count_out),
		.level_out         (level_out),
		.overflowed        (overflowed),
		.last              (last)
	);

	dpsq_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.opcode            (opcode),
		.queue_select      (queue_select),
		.customer_code     (customer_code),
		.item_count        (item_count),
		.level             (level),
		.strobe            (strobe),
		.entry_valid       (entry_valid),
		.customer_code_out (customer_code_out),
		.item_count_out    (item_count_out),
		.level_out         (level_out),
		.overflowed        (overflowed),
		.last              (last),
		.fail_count        (fails),
		.outstanding       (outstanding),
		.results_checked   (results_checked),
		.drops             (drops)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [15:0] rand16();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// level 0 is legal on the port and sorts below everything
	function automatic logic [LEVEL_W-1:0] pick_level();
		logic [LEVEL_W-1:0] l;
		if ($urandom_range(9) == 0)
			l = '0;
		else
			l = LEVEL_W'($urandom_range(1, 3));
		return l;
	endfunction

	task automatic request(opcode_t op, logic q, logic [CODE_W-1:0] c,
			logic [COUNT_W-1:0] n, logic [LEVEL_W-1:0] l);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start         <= 1'b1;
		opcode        <= op;
		queue_select  <= q;
		customer_code <= c;
		item_count    <= n;
		level         <= l;
		do
			@(posedge clk);
		while (busy);
		if (op == OP_INSERT)
			n_insert++;
		else
			n_drain++;
	endtask

	initial begin
		int i;
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = OP_INSERT;
		queue_select  = 1'b0;
		customer_code = '0;
		item_count    = '0;
		level         = '0;
		n_insert      = 0;
		n_drain       = 0;
		idle_pct      = 12;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queues first, then tie handling and level 0
		request(OP_DRAIN, 1'b0, 16'h1234, 16'h4321, 2'd3);
		request(OP_DRAIN, 1'b1, 16'hFFFF, 16'hFFFF, 2'd0);
		request(OP_INSERT, 1'b0, 16'h0000, 16'h0000, 2'd2);
		request(OP_INSERT, 1'b0, 16'hFFFF, 16'hFFFF, 2'd2);
		request(OP_INSERT, 1'b0, 16'hA5A5, 16'h5A5A, 2'd3);
		request(OP_INSERT, 1'b0, 16'h5A5A, 16'hA5A5, 2'd3);
		request(OP_INSERT, 1'b0, 16'h0001, 16'h8000, 2'd1);
		request(OP_INSERT, 1'b0, 16'h8000, 16'h0001, 2'd0);
		request(OP_INSERT, 1'b0, 16'h00FF, 16'hFF00, 2'd2);
		request(OP_DRAIN, 1'b0, 16'h0000, 16'h0000, 2'd0);
		request(OP_INSERT, 1'b1, 16'h1111, 16'h2222, 2'd1);
		request(OP_INSERT, 1'b1, 16'h3333, 16'h4444, 2'd3);
		request(OP_INSERT, 1'b1, 16'h5555, 16'h6666, 2'd1);
		request(OP_DRAIN, 1'b1, 16'h0000, 16'h0000, 2'd0);
		// fill queue 0 and push one past full
		for (i = 0; i < QUEUE_DEPTH - 6; i++)
			request(OP_INSERT, 1'b0, rand16(), rand16(), 2'(i % 4));
		request(OP_DRAIN, 1'b0, 16'h0000, 16'h0000, 2'd0);

		for (i = 0; i < 355; i++) begin
			if (i == 118)
				idle_pct = 57;
			else if (i == 236)
				idle_pct = 0;
			if ($urandom_range(99) < 60)
				request(OP_INSERT, 1'($urandom_range(1)), rand16(), rand16(),
					pick_level());
			else
				request(OP_DRAIN, 1'($urandom_range(1)), 16'($urandom), 16'($urandom),
					2'($urandom));
		end
		start <= 1'b0;

		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH + 4) @(posedge clk);

		$display("Covered %0d inserts (%0d dropped on full queues) and %0d drains,",
			n_insert, drops, n_drain);
		$display("%0d readout results compared against the shadow queues", results_checked);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
